[design/ctt_pkg.sv]
// Shared types, constants and character-class functions for the command text tokenizer.
`default_nettype none

package ctt_pkg;

    localparam int MAX_TEXT_BYTES = 4096;
    // Position counter must hold the capacity itself; token start stays below it.
    localparam int POS_W   = $clog2(MAX_TEXT_BYTES + 1);
    localparam int START_W = $clog2(MAX_TEXT_BYTES);
    localparam int QDEPTH  = 4;
    localparam int QIDX_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [START_W-1:0] tstart_t;
    typedef logic [11:0]        start_pos_t;
    typedef logic [12:0]        tok_len_t;
    typedef logic [QIDX_W-1:0]  qidx_t;
    typedef logic [QCNT_W-1:0]  qcnt_t;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOT  = 1'b1;

    typedef enum logic [2:0] {
        TT_NUMBER = 3'd0,
        TT_SYMBOL = 3'd1,
        TT_STRING = 3'd2,
        TT_SPACE  = 3'd3,
        TT_LF     = 3'd4
    } tok_type_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_SIGN     = 3'd1,
        MODE_NUM      = 3'd2,
        MODE_USTR     = 3'd3,
        MODE_USTR_ESC = 3'd4,
        MODE_QSTR     = 3'd5,
        MODE_QSTR_ESC = 3'd6
    } lex_mode_t;

    typedef struct packed {
        logic       command;
        logic [7:0] char_byte;
    } in_item_t;

    typedef struct packed {
        tok_type_t  token_type;
        start_pos_t start_pos;
        tok_len_t   token_length;
        logic       overflow;
        logic       last_in_run;
    } out_item_t;

    // Up to two tokens written into the result queue per item.
    typedef struct packed {
        logic      wr0;
        logic      wr1;
        out_item_t tok0;
        out_item_t tok1;
    } push_t;

    function automatic logic is_num(input logic [7:0] b);
        return ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_DOT);
    endfunction

    function automatic logic is_end(input logic [7:0] b);
        logic r;
        case (b)
            8'h20, 8'h2C, 8'h40, 8'h7E, 8'h5E, 8'h2F, 8'h24, 8'h26, 8'h22,
            8'h27, 8'h21, 8'h23, 8'h25, 8'h2B, 8'h2A, 8'h3D, 8'h5B, 8'h7B,
            8'h5D, 8'h7D, 8'h5C, 8'h7C, 8'h3C, 8'h3E, 8'h60, 8'h0A: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_sym(input logic [7:0] b);
        logic r;
        case (b)
            8'h2C, 8'h40, 8'h7E, 8'h5E, 8'h2F, 8'h24, 8'h26, 8'h27, 8'h21,
            8'h23, 8'h25, 8'h2B, 8'h2A, 8'h3D, 8'h5B, 8'h7B, 8'h5D, 8'h7D,
            8'h5C, 8'h7C, 8'h3C, 8'h3E, 8'h60, 8'h2D, 8'h3A: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[design/command_text_tokenizer.sv]
// Top level of the command text tokenizer: lexer feeding a four-entry result queue.
// Tokens are registered in the queue when their item is accepted and offered from its head;
// a second token from the same item is queued directly behind the first.
// Throughput: one byte item per cycle while two queue entries are free; the queue
// drains one token per cycle, so items that close one token and emit another fill it up.
// Reset (rst_n, async, active low) clears lexer mode, position, overflow and the queue.
`default_nettype none

module command_text_tokenizer
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire ctt_pkg::in_item_t  item,
    output logic                    tok_valid,
    input  wire logic               tok_ready,
    output ctt_pkg::out_item_t      tok
);

    ctt_pkg::push_t push;
    logic           space_ok;
    logic           accept;

    assign item_ready = space_ok;
    assign accept     = item_valid && space_ok;

    ctt_lexer u_lexer
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push)
    );

    ctt_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

endmodule

`default_nettype wire

[design/ctt_lexer.sv]
// Lexer state machine: classifies one byte per cycle while accept is high and produces up to two tokens.
`default_nettype none

module ctt_lexer
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire ctt_pkg::in_item_t item,
    output ctt_pkg::push_t        push
);

    ctt_pkg::lex_mode_t mode_reg, mode_next;
    ctt_pkg::pos_t      pos_reg, pos_next;
    ctt_pkg::tstart_t   start_reg, start_next;
    logic               ovf_reg, ovf_next;

    logic [7:0]          b;
    ctt_pkg::pos_t       len_run;
    ctt_pkg::pos_t       len_quote;
    logic                at_cap;

    // Result of opening a token on the current byte
    logic                o_emit;
    ctt_pkg::tok_type_t  o_type;
    ctt_pkg::lex_mode_t  o_mode;
    logic                o_load;

    // Token closed by the current item
    logic                c_emit;
    ctt_pkg::tok_type_t  c_type;
    ctt_pkg::pos_t       c_len;
    logic                do_open;

    ctt_pkg::out_item_t  close_tok;
    ctt_pkg::out_item_t  open_tok;

    assign b         = item.char_byte;
    assign len_run   = pos_reg - ctt_pkg::pos_t'(start_reg);
    assign len_quote = pos_reg + ctt_pkg::pos_t'(1) - ctt_pkg::pos_t'(start_reg);
    assign at_cap    = (pos_reg >= ctt_pkg::pos_t'(ctt_pkg::MAX_TEXT_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ctt_pkg::MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        o_emit = 1'b0;
        o_type = ctt_pkg::TT_STRING;
        o_mode = ctt_pkg::MODE_IDLE;
        o_load = 1'b0;
        if (b == ctt_pkg::CH_LF)
        begin
            o_emit = 1'b1;
            o_type = ctt_pkg::TT_LF;
        end
        else if (b == ctt_pkg::CH_SPACE)
        begin
            o_emit = 1'b1;
            o_type = ctt_pkg::TT_SPACE;
        end
        else if (ctt_pkg::is_num(b))
        begin
            o_mode = ctt_pkg::MODE_NUM;
            o_load = 1'b1;
        end
        else if ((b == ctt_pkg::CH_PLUS) || (b == ctt_pkg::CH_MINUS))
        begin
            o_mode = ctt_pkg::MODE_SIGN;
            o_load = 1'b1;
        end
        else if (ctt_pkg::is_sym(b))
        begin
            o_emit = 1'b1;
            o_type = ctt_pkg::TT_SYMBOL;
        end
        else if (b == ctt_pkg::CH_DQUOTE)
        begin
            o_mode = ctt_pkg::MODE_QSTR;
            o_load = 1'b1;
        end
        else
        begin
            o_mode = ctt_pkg::MODE_USTR;
            o_load = 1'b1;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        ovf_next   = ovf_reg;
        c_emit     = 1'b0;
        c_type     = ctt_pkg::TT_STRING;
        c_len      = len_run;
        do_open    = 1'b0;

        if (accept)
        begin
            if (item.command == ctt_pkg::CMD_EOT)
            begin
                // Flush any open token, then restart the text
                case (mode_reg)
                    ctt_pkg::MODE_IDLE:
                    begin
                        c_emit = 1'b0;
                    end
                    ctt_pkg::MODE_SIGN:
                    begin
                        c_emit = 1'b1;
                        c_type = ctt_pkg::TT_SYMBOL;
                        c_len  = ctt_pkg::pos_t'(1);
                    end
                    ctt_pkg::MODE_NUM:
                    begin
                        c_emit = 1'b1;
                        c_type = ctt_pkg::TT_NUMBER;
                    end
                    default:
                    begin
                        c_emit = 1'b1;
                    end
                endcase
                mode_next  = ctt_pkg::MODE_IDLE;
                pos_next   = '0;
                start_next = '0;
                ovf_next   = 1'b0;
            end
            else if (at_cap)
            begin
                // Drop the byte, keep position saturated
                ovf_next = 1'b1;
            end
            else
            begin
                case (mode_reg)
                    ctt_pkg::MODE_SIGN:
                    begin
                        if (ctt_pkg::is_num(b))
                        begin
                            mode_next = ctt_pkg::MODE_NUM;
                        end
                        else
                        begin
                            c_emit  = 1'b1;
                            c_type  = ctt_pkg::TT_SYMBOL;
                            c_len   = ctt_pkg::pos_t'(1);
                            do_open = 1'b1;
                        end
                    end
                    ctt_pkg::MODE_NUM:
                    begin
                        if (!(ctt_pkg::is_num(b) || (b == ctt_pkg::CH_PLUS) ||
                              (b == ctt_pkg::CH_MINUS)))
                        begin
                            c_emit  = 1'b1;
                            c_type  = ctt_pkg::TT_NUMBER;
                            do_open = 1'b1;
                        end
                    end
                    ctt_pkg::MODE_USTR:
                    begin
                        if (b == ctt_pkg::CH_BSLASH)
                        begin
                            mode_next = ctt_pkg::MODE_USTR_ESC;
                        end
                        else if (ctt_pkg::is_end(b))
                        begin
                            c_emit  = 1'b1;
                            do_open = 1'b1;
                        end
                    end
                    ctt_pkg::MODE_USTR_ESC:
                    begin
                        mode_next = ctt_pkg::MODE_USTR;
                    end
                    ctt_pkg::MODE_QSTR:
                    begin
                        if (b == ctt_pkg::CH_BSLASH)
                        begin
                            mode_next = ctt_pkg::MODE_QSTR_ESC;
                        end
                        else if (b == ctt_pkg::CH_DQUOTE)
                        begin
                            c_emit    = 1'b1;
                            c_len     = len_quote;
                            mode_next = ctt_pkg::MODE_IDLE;
                        end
                    end
                    ctt_pkg::MODE_QSTR_ESC:
                    begin
                        mode_next = ctt_pkg::MODE_QSTR;
                    end
                    default:
                    begin
                        do_open = 1'b1;
                    end
                endcase

                if (do_open)
                begin
                    mode_next = o_mode;
                    if (o_load)
                    begin
                        start_next = ctt_pkg::tstart_t'(pos_reg);
                    end
                end
                pos_next = pos_reg + ctt_pkg::pos_t'(1);
            end
        end
    end

    always_comb
    begin
        close_tok.token_type   = c_type;
        close_tok.start_pos    = ctt_pkg::start_pos_t'(start_reg);
        close_tok.token_length = ctt_pkg::tok_len_t'(c_len);
        close_tok.overflow     = ovf_reg;
        close_tok.last_in_run  = !(do_open && o_emit);

        open_tok.token_type    = o_type;
        open_tok.start_pos     = ctt_pkg::start_pos_t'(pos_reg);
        open_tok.token_length  = ctt_pkg::tok_len_t'(1);
        open_tok.overflow      = ovf_reg;
        open_tok.last_in_run   = 1'b1;

        push.wr0  = c_emit || (do_open && o_emit);
        push.wr1  = c_emit && do_open && o_emit;
        push.tok0 = c_emit ? close_tok : open_tok;
        push.tok1 = open_tok;
    end

endmodule

`default_nettype wire

[design/ctt_out_queue.sv]
// Result queue: takes up to two tokens per cycle, delivers one per handshake.
`default_nettype none

module ctt_out_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctt_pkg::push_t     push,
    output logic                    space_ok,
    output logic                    tok_valid,
    input  wire logic               tok_ready,
    output ctt_pkg::out_item_t      tok
);

    ctt_pkg::out_item_t entry_reg [ctt_pkg::QDEPTH];
    ctt_pkg::qidx_t     wr_ptr_reg, wr_ptr_next;
    ctt_pkg::qidx_t     rd_ptr_reg, rd_ptr_next;
    ctt_pkg::qcnt_t     count_reg, count_next;
    ctt_pkg::qidx_t     wr_ptr_plus1;
    logic               pop;

    assign wr_ptr_plus1 = wr_ptr_reg + ctt_pkg::qidx_t'(1);
    assign tok_valid    = (count_reg != '0);
    assign tok          = entry_reg[rd_ptr_reg];
    assign pop          = tok_valid && tok_ready;
    // Accept an item only when both of its possible tokens fit
    assign space_ok     = (count_reg <= ctt_pkg::qcnt_t'(ctt_pkg::QDEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.wr0 && push.wr1)
        begin
            wr_ptr_next = wr_ptr_reg + ctt_pkg::qidx_t'(2);
            count_next  = count_next + ctt_pkg::qcnt_t'(2);
        end
        else if (push.wr0)
        begin
            wr_ptr_next = wr_ptr_plus1;
            count_next  = count_next + ctt_pkg::qcnt_t'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + ctt_pkg::qidx_t'(1);
            count_next  = count_next - ctt_pkg::qcnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.wr0)
        begin
            entry_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.wr1)
        begin
            entry_reg[wr_ptr_plus1] <= push.tok1;
        end
    end

endmodule

`default_nettype wire

[design/ctt_checker.sv]
// Port-level checks for the command text tokenizer, bound to the top level.
`default_nettype none

module ctt_checker
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic               item_ready,
    input  wire ctt_pkg::in_item_t  item,
    input  wire logic               tok_valid,
    input  wire logic               tok_ready,
    input  wire ctt_pkg::out_item_t tok
);

    // Hold a stalled input item unchanged
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_ready) |=> (item_valid && $stable(item)))
        else $error("stalled input item changed or dropped");

    // Hold a stalled token unchanged
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_ready) |=> (tok_valid && $stable(tok)))
        else $error("stalled token changed or dropped");

    // Input stalls only while tokens are waiting
    a_stall_has_tok: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> tok_valid)
        else $error("input stalled with empty queue");

    // Second token of an item is already queued when the first leaves
    a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_ready && !tok.last_in_run) |=> tok_valid)
        else $error("token run broken");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> (tok.token_length != '0))
        else $error("zero-length token");

endmodule

bind command_text_tokenizer ctt_checker u_ctt_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok        (tok)
);

`default_nettype wire
